// File: rtl/sau_pkg.sv
// Shared types, codes and constants for the stack access address unit.
// No dependencies.
package sau_pkg;

    localparam int ADDR_W                = 32;
    localparam int SLOT_W                = 3;
    localparam int OP_W                  = 4;
    localparam int MULTI_REGISTER_COUNT  = 8;
    localparam int BEAT_W                = $clog2(MULTI_REGISTER_COUNT);
    localparam int KMUL_W                = BEAT_W + 1;
    localparam int DELTA_W               = KMUL_W + 2;

    localparam logic [ADDR_W-1:0] MASK16 = 32'h0000_FFFF;
    localparam logic [SLOT_W-1:0] SAVED_SP_SLOT = 3'd4;
    localparam logic [BEAT_W-1:0] FINAL_BEAT = BEAT_W'(MULTI_REGISTER_COUNT - 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_SP = 4'd0,
        OP_PUSH16  = 4'd1,
        OP_PUSH32  = 4'd2,
        OP_POP16   = 4'd3,
        OP_POP32   = 4'd4,
        OP_PUSHA   = 4'd5,
        OP_PUSHAD  = 4'd6,
        OP_POPA    = 4'd7,
        OP_POPAD   = 4'd8
    } op_t;

    typedef enum logic {
        CFG_STACK_IS_32BIT = 1'b0,
        CFG_SEGMENT_BASE   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              access_valid;
        logic              is_write;
        logic              access_wide;
        logic [ADDR_W-1:0] linear_address;
        logic [ADDR_W-1:0] write_value;
        logic [SLOT_W-1:0] register_slot;
        logic              slot_from_register_file;
        logic              discard_read;
        logic [ADDR_W-1:0] new_stack_pointer;
        logic              last;
    } result_t;

    // Beat generator status towards the sequencer
    typedef struct packed {
        logic drop;    // unknown code: consumed, nothing emitted
        logic multi;   // multi-register operation, advances the beat count
        logic last;    // final beat of the item
    } beat_status_t;

endpackage

// File: rtl/sau_if.sv
// Channel interfaces: request, result and configuration write.
// Depends on sau_pkg.
interface sau_req_if;
    logic                          valid;
    logic                          ready;
    logic [sau_pkg::OP_W-1:0]      operation;
    logic [sau_pkg::ADDR_W-1:0]    operand_value;

    modport source (output valid, output operation, output operand_value, input ready);
    modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface sau_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          access_valid;
    logic                          is_write;
    logic                          access_wide;
    logic [sau_pkg::ADDR_W-1:0]    linear_address;
    logic [sau_pkg::ADDR_W-1:0]    write_value;
    logic [sau_pkg::SLOT_W-1:0]    register_slot;
    logic                          slot_from_register_file;
    logic                          discard_read;
    logic [sau_pkg::ADDR_W-1:0]    new_stack_pointer;
    logic                          last;

    modport source (output valid, output access_valid, output is_write, output access_wide,
                    output linear_address, output write_value, output register_slot,
                    output slot_from_register_file, output discard_read,
                    output new_stack_pointer, output last, input ready);
    modport sink   (input valid, input access_valid, input is_write, input access_wide,
                    input linear_address, input write_value, input register_slot,
                    input slot_from_register_file, input discard_read,
                    input new_stack_pointer, input last, output ready);
endinterface

interface sau_cfg_if;
    logic                          valid;
    logic                          ready;
    logic                          index;
    logic [sau_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/stack_access_address_unit.sv
// Top level of the stack access address unit: item register, pointer state,
// beat generator and result register. Depends on sau_pkg, sau_if, sau_beat_gen, sau_out_stage.
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+----------------------------------------------
//  cfg     | in  | valid/ready   | index (0 stack_is_32bit, 1 base), data
//  req     | in  | valid/ready   | operation, operand_value
//  rsp     | out | valid/ready   | one access request per beat; one or eight per item
//
// Timing: load, push and pop items issue one beat each, back to back; pusha,
// pushad, popa and popad issue eight beats, one beat per cycle while rsp is not
// stalled, paced by the beat counter walking the held item. Unknown codes are
// taken and dropped with no beat issued. Reset: pointer 0, 16-bit wrap, segment base 0,
// nothing in flight. Stalls: the result register holds a beat while rsp is stalled
// and the held item waits; req is ready when no item is held or the held item issues
// its final beat.
module stack_access_address_unit (
    input  logic       clk,
    input  logic       rst_n,
    sau_cfg_if.sink    cfg,
    sau_req_if.sink    req,
    sau_rsp_if.source  rsp
);

    // configuration
    logic                        is32_reg;
    logic [sau_pkg::ADDR_W-1:0]  ss_base_reg;

    // held item
    logic                        item_valid_reg;
    logic                        item_valid_next;
    logic [sau_pkg::OP_W-1:0]    item_op_reg;
    logic [sau_pkg::ADDR_W-1:0]  item_val_reg;

    // architectural state
    logic [sau_pkg::ADDR_W-1:0]  sp_reg;
    logic [sau_pkg::BEAT_W-1:0]  beat_reg;

    sau_pkg::result_t      beat_result;
    sau_pkg::beat_status_t beat_status;
    logic                  out_space;
    logic                  fire;
    logic                  done;
    logic                  take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is32_reg    <= 1'b0;
            ss_base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sau_pkg::CFG_STACK_IS_32BIT: is32_reg    <= cfg.data[0];
                sau_pkg::CFG_SEGMENT_BASE:   ss_base_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    sau_beat_gen u_beat_gen (
        .op       (item_op_reg),
        .operand  (item_val_reg),
        .sp       (sp_reg),
        .beat     (beat_reg),
        .is32     (is32_reg),
        .ss_base  (ss_base_reg),
        .result   (beat_result),
        .status   (beat_status)
    );

    // A dropped code needs no room in the result register
    assign fire = item_valid_reg && (beat_status.drop || out_space);
    assign done = fire && (beat_status.drop || beat_status.last);

    assign req.ready       = !item_valid_reg || done;
    assign take            = req.valid && req.ready;
    assign item_valid_next = take || (item_valid_reg && !done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_op_reg  <= req.operation;
            item_val_reg <= req.operand_value;
        end
    end

    // Pointer moves once per item, on its final beat; beat count wraps to 0 after eight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            beat_reg <= '0;
        end
        else if (fire && !beat_status.drop)
        begin
            if (beat_status.last)
                sp_reg <= beat_result.new_stack_pointer;
            if (beat_status.multi)
                beat_reg <= beat_reg + 1'b1;
        end
    end

    sau_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire && !beat_status.drop),
        .result (beat_result),
        .space  (out_space),
        .rsp    (rsp)
    );

endmodule

// File: rtl/sau_beat_gen.sv
// Combinational beat generator: one result from the held item, pointer and beat.
// Depends on sau_pkg.
module sau_beat_gen (
    input  logic [sau_pkg::OP_W-1:0]    op,
    input  logic [sau_pkg::ADDR_W-1:0]  operand,
    input  logic [sau_pkg::ADDR_W-1:0]  sp,
    input  logic [sau_pkg::BEAT_W-1:0]  beat,
    input  logic                        is32,
    input  logic [sau_pkg::ADDR_W-1:0]  ss_base,
    output sau_pkg::result_t            result,
    output sau_pkg::beat_status_t       status
);

    logic [sau_pkg::ADDR_W-1:0]  mask;
    logic [sau_pkg::ADDR_W-1:0]  off_addr;
    logic [sau_pkg::ADDR_W-1:0]  off_nsp;
    logic [sau_pkg::KMUL_W-1:0]  k_addr;
    logic [sau_pkg::KMUL_W-1:0]  k_nsp;
    logic [sau_pkg::DELTA_W-1:0] d_addr;
    logic [sau_pkg::DELTA_W-1:0] d_nsp;
    logic [sau_pkg::SLOT_W-1:0]  slot;
    logic                        wide;
    logic                        down;
    logic                        is_push1;
    logic                        is_pop1;
    logic                        is_pusha;
    logic                        is_popa;

    assign mask = is32 ? '1 : sau_pkg::MASK16;

    always_comb
    begin
        is_push1 = 1'b0;
        is_pop1  = 1'b0;
        is_pusha = 1'b0;
        is_popa  = 1'b0;
        wide     = 1'b0;
        status   = '0;
        case (op)
            sau_pkg::OP_LOAD_SP: ;
            sau_pkg::OP_PUSH16:  is_push1 = 1'b1;
            sau_pkg::OP_PUSH32:  begin is_push1 = 1'b1; wide = 1'b1; end
            sau_pkg::OP_POP16:   is_pop1 = 1'b1;
            sau_pkg::OP_POP32:   begin is_pop1 = 1'b1; wide = 1'b1; end
            sau_pkg::OP_PUSHA:   is_pusha = 1'b1;
            sau_pkg::OP_PUSHAD:  begin is_pusha = 1'b1; wide = 1'b1; end
            sau_pkg::OP_POPA:    is_popa = 1'b1;
            sau_pkg::OP_POPAD:   begin is_popa = 1'b1; wide = 1'b1; end
            default:             status.drop = 1'b1;
        endcase
        status.multi = is_pusha | is_popa;
        status.last  = !(is_pusha | is_popa) || (beat == sau_pkg::FINAL_BEAT);
    end

    // Step multiples: pushes predecrement, pops read at the current offset
    always_comb
    begin
        down = is_push1 | is_pusha;
        if (is_pusha)
            k_addr = sau_pkg::KMUL_W'(beat) + 1'b1;
        else if (is_popa)
            k_addr = sau_pkg::KMUL_W'(beat);
        else if (is_push1)
            k_addr = sau_pkg::KMUL_W'(1);
        else
            k_addr = '0;
        k_nsp = (is_pusha | is_popa) ? sau_pkg::KMUL_W'(sau_pkg::MULTI_REGISTER_COUNT)
                                     : sau_pkg::KMUL_W'(1);
    end

    assign d_addr = sau_pkg::DELTA_W'(k_addr) << (wide ? 2 : 1);
    assign d_nsp  = sau_pkg::DELTA_W'(k_nsp)  << (wide ? 2 : 1);

    assign off_addr = (down ? sp - sau_pkg::ADDR_W'(d_addr)
                            : sp + sau_pkg::ADDR_W'(d_addr)) & mask;
    assign off_nsp  = (down ? sp - sau_pkg::ADDR_W'(d_nsp)
                            : sp + sau_pkg::ADDR_W'(d_nsp)) & mask;

    // popa walks the slots downwards
    assign slot = is_popa ? sau_pkg::SLOT_W'(sau_pkg::FINAL_BEAT - beat)
                          : sau_pkg::SLOT_W'(beat);

    always_comb
    begin
        result      = '0;
        result.last = status.last;
        if (op == sau_pkg::OP_LOAD_SP)
            result.new_stack_pointer = operand;
        else
        begin
            result.access_valid      = 1'b1;
            result.is_write          = down;
            result.access_wide       = wide;
            result.linear_address    = off_addr + ss_base;
            result.new_stack_pointer = off_nsp | (sp & ~mask);
            if (is_push1)
                result.write_value = wide ? operand : (operand & sau_pkg::MASK16);
            if (status.multi)
            begin
                result.register_slot           = slot;
                result.slot_from_register_file = (slot != sau_pkg::SAVED_SP_SLOT);
                result.discard_read            = is_popa && (slot == sau_pkg::SAVED_SP_SLOT);
                if (is_pusha && slot == sau_pkg::SAVED_SP_SLOT)
                    result.write_value = wide ? sp : (sp & sau_pkg::MASK16);
            end
        end
    end

endmodule

// File: rtl/sau_out_stage.sv
// Result register towards the result channel.
// Depends on sau_pkg and sau_rsp_if.
module sau_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sau_pkg::result_t  result,
    output logic              space,
    sau_rsp_if.source         rsp
);

    logic             valid_reg;
    logic             valid_next;
    sau_pkg::result_t data_reg;

    assign space      = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign rsp.valid                   = valid_reg;
    assign rsp.access_valid            = data_reg.access_valid;
    assign rsp.is_write                = data_reg.is_write;
    assign rsp.access_wide             = data_reg.access_wide;
    assign rsp.linear_address          = data_reg.linear_address;
    assign rsp.write_value             = data_reg.write_value;
    assign rsp.register_slot           = data_reg.register_slot;
    assign rsp.slot_from_register_file = data_reg.slot_from_register_file;
    assign rsp.discard_read            = data_reg.discard_read;
    assign rsp.new_stack_pointer       = data_reg.new_stack_pointer;
    assign rsp.last                    = data_reg.last;

endmodule

// File: rtl/sau_checker.sv
// Port-level checks for the stack access address unit, bound to the top level.
// Depends on sau_pkg.
module sau_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_access_valid,
    input logic                        rsp_is_write,
    input logic [sau_pkg::ADDR_W-1:0]  rsp_linear_address,
    input logic [sau_pkg::SLOT_W-1:0]  rsp_register_slot,
    input logic                        rsp_slot_from_register_file,
    input logic                        rsp_discard_read,
    input logic [sau_pkg::ADDR_W-1:0]  rsp_new_stack_pointer,
    input logic                        rsp_last
);

    // stalled beat holds its address
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_linear_address))
        else $error("stalled result changed");

    // a pointer load carries no access and closes its item
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_access_valid |-> rsp_last && !rsp_is_write &&
        rsp_linear_address == '0 && rsp_register_slot == '0)
        else $error("pointer load result malformed");

    // discarded read is the saved-pointer slot of a multi-register pop
    a_discard: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_discard_read |-> !rsp_is_write && !rsp_slot_from_register_file &&
        rsp_register_slot == sau_pkg::SAVED_SP_SLOT)
        else $error("discard on wrong beat");

    // beats of one item follow without a gap and share the final pointer
    a_beats: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last |=> rsp_valid &&
        $stable(rsp_new_stack_pointer) && $stable(rsp_is_write))
        else $error("multi-register beats broken");

endmodule

bind stack_access_address_unit sau_checker u_sau_checker (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .rsp_valid                   (rsp.valid),
    .rsp_ready                   (rsp.ready),
    .rsp_access_valid            (rsp.access_valid),
    .rsp_is_write                (rsp.is_write),
    .rsp_linear_address          (rsp.linear_address),
    .rsp_register_slot           (rsp.register_slot),
    .rsp_slot_from_register_file (rsp.slot_from_register_file),
    .rsp_discard_read            (rsp.discard_read),
    .rsp_new_stack_pointer       (rsp.new_stack_pointer),
    .rsp_last                    (rsp.last)
);
